// File: design/cal_pkg.sv
// Shared types, constants and calendar functions for the calendar date counter.
package cal_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int DOY_W   = 9;

   localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
   localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd2000;
   localparam logic [DOY_W-1:0]   DAYS_NORMAL = 9'd365;
   localparam logic [DOY_W-1:0]   DAYS_LEAP   = 9'd366;
   localparam logic [MONTH_W-1:0] MONTH_JAN   = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;

   // request kinds carried on tuser
   typedef enum logic [0:0] {
      OP_LOAD    = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

   // one full date as held and reported
   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      logic [DOY_W-1:0]   doy;
      logic               leap;
   } date_type;

   // Gregorian leap rule; y/100 through a reciprocal multiply (exact below 43699)
   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      logic [27:0]       prod;
      logic [7:0]        q;
      logic [13:0]       qx100;
      logic [YEAR_W-1:0] r;
      prod  = {14'd0, y} * 28'd5243;
      q     = prod[26:19];
      qx100 = {6'd0, q} * 14'd100;
      r     = y - qx100;
      if (r == '0) begin
         return (q[1:0] == 2'd0);
      end
      return (y[1:0] == 2'd0);
   endfunction

   // month length; out-of-range month codes read as 31
   function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                     input logic lp);
      logic [DAY_W-1:0] n;
      case (m) inside
         4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
         MONTH_FEB:               n = lp ? 5'd29 : 5'd28;
         default:                 n = 5'd31;
      endcase
      return n;
   endfunction

   // days in the months before month m
   function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m,
                                                   input logic lp);
      logic [DOY_W-1:0] n;
      case (m)
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      if (lp && (m > MONTH_FEB)) begin
         n = n + 9'd1;
      end
      return n;
   endfunction

endpackage

// File: design/cal_step.sv
// Next-date logic: load from day-of-year and year, or advance the held date one day.
module cal_step (
   input  logic                       op,
   input  logic [cal_pkg::DOY_W-1:0]  load_doy,
   input  logic [cal_pkg::YEAR_W-1:0] load_year,
   input  cal_pkg::date_type          cur,
   output cal_pkg::date_type          nxt,
   output logic                       load_error
);
   import cal_pkg::*;

   logic [YEAR_W-1:0]  ld_year;
   logic               ld_leap;
   logic               ld_bad;
   logic [MONTH_W-1:0] ld_month;
   logic [DOY_W-1:0]   ld_offset;
   logic [DOY_W-1:0]   ld_day;
   logic [DAY_W-1:0]   adv_dim;
   logic [YEAR_W-1:0]  adv_year;

   // load: saturate year, range check, month by parallel compares
   always_comb begin
      ld_year  = (load_year > YEAR_MAX) ? YEAR_MAX : load_year;
      ld_leap  = is_leap(ld_year);
      ld_bad   = (load_doy == '0) || (load_doy > (ld_leap ? DAYS_LEAP : DAYS_NORMAL));
      ld_month = MONTH_JAN;
      for (int k = 2; k <= 12; k++) begin
         if (load_doy > days_before(MONTH_W'(k), ld_leap)) begin
            ld_month = MONTH_W'(k);
         end
      end
      ld_offset = days_before(ld_month, ld_leap);
      ld_day    = load_doy - ld_offset;
   end

   // advance: year after December 31 wraps past the top year to zero
   assign adv_dim  = days_in_month(cur.month, cur.leap);
   assign adv_year = (cur.year >= YEAR_MAX) ? '0 : cur.year + 14'd1;

   always_comb begin
      nxt        = cur;
      load_error = 1'b0;
      if (op == OP_LOAD) begin
         nxt.year = ld_year;
         nxt.leap = ld_leap;
         if (ld_bad) begin
            nxt.day    = 5'd1;
            nxt.month  = MONTH_JAN;
            nxt.doy    = 9'd1;
            load_error = 1'b1;
         end else begin
            nxt.day   = ld_day[DAY_W-1:0];
            nxt.month = ld_month;
            nxt.doy   = load_doy;
         end
      end else begin
         if (cur.day >= adv_dim) begin
            nxt.day = 5'd1;
            if (cur.month >= MONTH_DEC) begin
               nxt.month = MONTH_JAN;
               nxt.year  = adv_year;
               nxt.leap  = is_leap(adv_year);
               nxt.doy   = 9'd1;
            end else begin
               nxt.month = cur.month + 4'd1;
               nxt.doy   = cur.doy + 9'd1;
            end
         end else begin
            nxt.day = cur.day + 5'd1;
            nxt.doy = cur.doy + 9'd1;
         end
      end
   end

endmodule

// File: design/calendar_date_counter.sv
// Top level of the calendar date counter: request register, date state, response register.
//
// Holds a Gregorian date and returns one response for every request.
// Request channel (req_*): tuser carries the kind (load or advance one day),
// tdata carries the day-of-year and year used by a load.
// Response channel (rsp_*): the date after the request, its day-of-year, the
// leap flag of its year and a flag for a load with an out-of-range day number.
// An accepted request is first held in the request register and then passes
// through the date logic into the response register.
// Throughput: one request per cycle unless the receiver stalls; the date update
// is a single pass of compare and add logic between the request register and
// the date register. A response waiting in the output register does not block
// the request register from taking the next request; when the receiver stalls,
// the request register fills and req_tready drops until the response is taken.
// Reset (synchronous, active high) empties both registers and sets the date
// to January 1, 2000.
module calendar_date_counter (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // [8:0] load_day_of_year, [22:9] load_year, [23] zero
   input  logic [0:0]  req_tuser,  // [0] op
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // [4:0] cur_day, [8:5] cur_month, [22:9] cur_year,
                                   // [31:23] cur_day_of_year, [32] leap, [33] load_error,
                                   // [39:34] zero
);
   import cal_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic              in_op_ff;
   logic [DOY_W-1:0]  in_doy_ff;
   logic [YEAR_W-1:0] in_year_ff;
   date_type          date_ff, date_in;
   logic              rsp_valid_ff, rsp_valid_in;
   date_type          rsp_date_ff;
   logic              rsp_err_ff;
   logic              in_move;
   logic              step_err;

   // handshake
   assign in_move     = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || in_move;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !in_move);
   assign rsp_valid_in = in_move || (rsp_valid_ff && !rsp_tready);

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_op_ff   <= req_tuser[0];
         in_doy_ff  <= req_tdata[8:0];
         in_year_ff <= req_tdata[22:9];
      end
   end

   cal_step u_step (
      .op         (in_op_ff),
      .load_doy   (in_doy_ff),
      .load_year  (in_year_ff),
      .cur        (date_ff),
      .nxt        (date_in),
      .load_error (step_err)
   );

   // held date
   always_ff @(posedge clock) begin
      if (reset) begin
         date_ff.day   <= 5'd1;
         date_ff.month <= MONTH_JAN;
         date_ff.year  <= RESET_YEAR;
         date_ff.doy   <= 9'd1;
         date_ff.leap  <= 1'b1;
      end else if (in_move) begin
         date_ff <= date_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (in_move) begin
         rsp_date_ff <= date_in;
         rsp_err_ff  <= step_err;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_err_ff, rsp_date_ff.leap, rsp_date_ff.doy,
                        rsp_date_ff.year, rsp_date_ff.month, rsp_date_ff.day};

endmodule

// File: design/cal_checker.sv
// Port-level checks on the calendar date counter response channel, bound to the top level.
module cal_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   import cal_pkg::*;

   logic [DAY_W-1:0]   c_day;
   logic [MONTH_W-1:0] c_month;
   logic [YEAR_W-1:0]  c_year;
   logic [DOY_W-1:0]   c_doy;
   logic               c_leap;
   logic               c_err;

   assign c_day   = rsp_tdata[4:0];
   assign c_month = rsp_tdata[8:5];
   assign c_year  = rsp_tdata[22:9];
   assign c_doy   = rsp_tdata[31:23];
   assign c_leap  = rsp_tdata[32];
   assign c_err   = rsp_tdata[33];

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // reported date stays a legal date
   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> c_day != '0 && c_month != '0 && c_month <= MONTH_DEC
                     && c_year <= YEAR_MAX && c_doy != '0 && c_doy <= DAYS_LEAP)
      else $error("date out of range");

   // a rejected load lands on January 1
   a_err_jan1: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && c_err |-> c_day == 5'd1 && c_month == MONTH_JAN && c_doy == 9'd1)
      else $error("load error without January 1");

   // day-of-year agrees with the day in January
   a_jan_doy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && c_month == MONTH_JAN |-> c_doy == {4'd0, c_day})
      else $error("day-of-year mismatch in January");

   // leap years are multiples of four
   a_leap_mod4: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && c_leap |-> c_year[1:0] == 2'd0)
      else $error("leap flag on a year not divisible by four");

endmodule

bind calendar_date_counter cal_checker u_cal_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
